// ===== sv/imhq_pkg.sv =====
// Shared types and constants for the indexed min-heap queue.
// No dependencies; imported by imhq_ctrl, imhq_dp and the top level.
`default_nettype none
package imhq_pkg;

  localparam int KEY_W  = 8;
  localparam int KEYS   = 256;
  localparam int INP_W  = 32;
  localparam int CNT_OW = 9;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CHANGE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_EX_TAKE, S_CH_TAKE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_INS, OP_EX_RD, OP_EX_TAKE, OP_CH_RD, OP_CH_TAKE,
    OP_UP_RD, OP_UP_SWAP, OP_DN_RD, OP_DN_SWAP, OP_FINAL
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    finish;
    status_t st;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       present;
    logic       slot_bad;
    logic       empty;
    logic       last_one;
    logic       at_root;
    logic       no_left;
    logic       up_less;
    logic       dn_less;
    logic       ch_gt;
    logic       ch_lt;
  } flags_t;

endpackage
`default_nettype wire

// ===== sv/imhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/imhq_ctrl.sv =====
// Sequencer for the indexed min-heap queue: decodes commands, steps sifts.
// Depends on imhq_pkg.
`default_nettype none
module imhq_ctrl import imhq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire flags_t flags,
  output logic        busy,
  output ctl_t        ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctl.op     = OP_NONE;
    ctl.finish = 1'b0;
    ctl.st     = ST_OK;
    busy       = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.op    = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (flags.cmd)
          CMD_INSERT: begin
            if (flags.full) begin
              ctl.finish = 1'b1; ctl.st = ST_FULL; state_nxt = S_IDLE;
            end else if (flags.present) begin
              ctl.finish = 1'b1; ctl.st = ST_PRESENT; state_nxt = S_IDLE;
            end else begin
              ctl.op = OP_INS; state_nxt = S_UP_RD;
            end
          end
          CMD_EXTRACT: begin
            if (flags.empty) begin
              ctl.finish = 1'b1; ctl.st = ST_EMPTY; state_nxt = S_IDLE;
            end else begin
              ctl.op = OP_EX_RD; state_nxt = S_EX_TAKE;
            end
          end
          CMD_CHANGE: begin
            if (flags.slot_bad) begin
              ctl.finish = 1'b1; ctl.st = ST_ABSENT; state_nxt = S_IDLE;
            end else begin
              ctl.op = OP_CH_RD; state_nxt = S_CH_TAKE;
            end
          end
          default: begin
            ctl.finish = 1'b1; state_nxt = S_IDLE;
          end
        endcase
      end
      S_EX_TAKE: begin
        ctl.op = OP_EX_TAKE;
        if (flags.last_one) begin
          ctl.finish = 1'b1; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_CH_TAKE: begin
        ctl.op = OP_CH_TAKE;
        if (flags.ch_gt) begin
          state_nxt = S_DN_RD;
        end else if (flags.ch_lt) begin
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (flags.at_root) begin
          ctl.op = OP_FINAL; ctl.finish = 1'b1; state_nxt = S_IDLE;
        end else begin
          ctl.op = OP_UP_RD; state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (flags.up_less) begin
          ctl.op = OP_UP_SWAP; state_nxt = S_UP_RD;
        end else begin
          ctl.op = OP_FINAL; ctl.finish = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_DN_RD: begin
        if (flags.no_left) begin
          ctl.op = OP_FINAL; ctl.finish = 1'b1; state_nxt = S_IDLE;
        end else begin
          ctl.op = OP_DN_RD; state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (flags.dn_less) begin
          ctl.op = OP_DN_SWAP; state_nxt = S_DN_RD;
        end else begin
          ctl.op = OP_FINAL; ctl.finish = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/imhq_dp.sv =====
// Datapath: heap and key-map storage, slot pointer, moving entry, results.
// Depends on imhq_pkg and imhq_ram.
`default_nettype none
module imhq_dp import imhq_pkg::*; #(
  parameter int CAPACITY      = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [KEY_W-1:0]  in_item_key,
  input  wire logic [INP_W-1:0]  in_item_priority,
  input  wire ctl_t              ctl,
  output flags_t                 flags,
  output logic                   out_valid,
  output logic [KEY_W-1:0]       out_key,
  output logic [INP_W-1:0]       out_priority,
  output logic [2:0]             out_status,
  output logic [CNT_OW-1:0]      out_entry_count
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam int PB = PRIORITY_BITS;
  localparam int EW = KEY_W + PB;
  localparam int KW = $clog2(KEYS);

  logic [1:0]        cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [PB-1:0]     prio_r;
  logic [CW-1:0]     count_r;
  logic [IW-1:0]     s_r;
  logic [KEY_W-1:0]  cur_key_r;
  logic [PB-1:0]     cur_prio_r;
  logic [KEYS-1:0]   present_r;
  logic [KEY_W-1:0]  okey_r;
  logic [INP_W-1:0]  oprio_r;
  logic [2:0]        st_r;
  logic              valid_r;

  logic [63:0]       in_p64;
  logic [PB-1:0]     in_prio;
  logic [63:0]       root_p64;
  logic [EW-1:0]     ha_rd, hb_rd, h_wdata;
  logic [IW-1:0]     ha_raddr, hb_raddr, map_rd, map_wdata;
  logic [KW-1:0]     map_waddr;
  logic              h_we, map_we;
  logic [KEY_W-1:0]  ha_k, hb_k, best_k;
  logic [PB-1:0]     ha_p, hb_p, best_p;
  logic [XW-1:0]     lidx, ridx, cnt_x;
  logic [IW-1:0]     parent, best_idx;
  logic              r_win;
  logic [31:0]       cnt32;

  assign in_p64  = {{(64 - INP_W){in_item_priority[INP_W-1]}}, in_item_priority};
  assign in_prio = in_p64[PB-1:0];

  assign ha_k = ha_rd[EW-1 -: KEY_W];
  assign ha_p = ha_rd[PB-1:0];
  assign hb_k = hb_rd[EW-1 -: KEY_W];
  assign hb_p = hb_rd[PB-1:0];

  assign cnt_x  = XW'(count_r);
  assign lidx   = {1'b0, s_r, 1'b1};
  assign ridx   = lidx + XW'(1);
  assign parent = (s_r - IW'(1)) >> 1;
  assign r_win  = (ridx < cnt_x) && ($signed(hb_p) < $signed(ha_p));
  assign best_k   = r_win ? hb_k : ha_k;
  assign best_p   = r_win ? hb_p : ha_p;
  assign best_idx = r_win ? ridx[IW-1:0] : lidx[IW-1:0];

  always_comb begin
    ha_raddr  = '0;
    hb_raddr  = '0;
    h_we      = 1'b0;
    h_wdata   = {cur_key_r, cur_prio_r};
    map_we    = 1'b0;
    map_waddr = cur_key_r;
    map_wdata = s_r;
    unique case (ctl.op)
      OP_EX_RD: begin
        hb_raddr = IW'(count_r - CW'(1));
      end
      OP_CH_RD:  ha_raddr = map_rd;
      OP_UP_RD:  ha_raddr = parent;
      OP_DN_RD: begin
        ha_raddr = lidx[IW-1:0];
        hb_raddr = ridx[IW-1:0];
      end
      OP_UP_SWAP: begin
        h_we = 1'b1; h_wdata = ha_rd;
        map_we = 1'b1; map_waddr = ha_k;
      end
      OP_DN_SWAP: begin
        h_we = 1'b1; h_wdata = {best_k, best_p};
        map_we = 1'b1; map_waddr = best_k;
      end
      OP_FINAL: begin
        h_we = 1'b1;
        map_we = 1'b1;
      end
      default: ;
    endcase
  end

  // two copies of the heap give two read ports
  imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(IW)) u_heap_a (
    .clk, .we(h_we), .waddr(s_r), .wdata(h_wdata), .raddr(ha_raddr), .rdata(ha_rd)
  );
  imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(IW)) u_heap_b (
    .clk, .we(h_we), .waddr(s_r), .wdata(h_wdata), .raddr(hb_raddr), .rdata(hb_rd)
  );
  imhq_ram #(.WIDTH(IW), .DEPTH(KEYS), .AW(KW)) u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata), .raddr(in_item_key),
    .rdata(map_rd)
  );

  assign root_p64 = {{(64 - PB){ha_p[PB-1]}}, ha_p};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      present_r <= '0;
      valid_r   <= 1'b0;
      st_r      <= ST_OK;
      okey_r    <= '0;
      oprio_r   <= '0;
    end else begin
      valid_r <= ctl.finish;
      if (ctl.finish) begin
        st_r <= ctl.st;
      end
      unique case (ctl.op)
        OP_LATCH: begin
          cmd_r   <= in_cmd;
          key_r   <= in_item_key;
          prio_r  <= in_prio;
          okey_r  <= '0;
          oprio_r <= '0;
        end
        OP_INS: begin
          cur_key_r  <= key_r;
          cur_prio_r <= prio_r;
          s_r        <= IW'(count_r);
          count_r    <= count_r + CW'(1);
          present_r[key_r] <= 1'b1;
        end
        OP_EX_TAKE: begin
          okey_r  <= ha_k;
          oprio_r <= root_p64[INP_W-1:0];
          present_r[ha_k] <= 1'b0;
          count_r    <= count_r - CW'(1);
          cur_key_r  <= hb_k;
          cur_prio_r <= hb_p;
          s_r        <= '0;
        end
        OP_CH_RD: s_r <= map_rd;
        OP_CH_TAKE: begin
          cur_key_r  <= key_r;
          cur_prio_r <= prio_r;
        end
        OP_UP_SWAP: s_r <= parent;
        OP_DN_SWAP: s_r <= best_idx;
        default: ;
      endcase
    end
  end

  always_comb begin
    flags.cmd      = cmd_r;
    flags.full     = (count_r >= CW'(CAPACITY));
    flags.present  = present_r[key_r];
    flags.slot_bad = !present_r[key_r] || (CW'(map_rd) >= count_r);
    flags.empty    = (count_r == '0);
    flags.last_one = (count_r == CW'(1));
    flags.at_root  = (s_r == '0);
    flags.no_left  = (lidx >= cnt_x);
    flags.up_less  = $signed(cur_prio_r) < $signed(ha_p);
    flags.dn_less  = $signed(best_p) < $signed(cur_prio_r);
    flags.ch_gt    = $signed(prio_r) > $signed(ha_p);
    flags.ch_lt    = $signed(prio_r) < $signed(ha_p);
  end

  assign cnt32           = 32'(count_r);
  assign out_valid       = valid_r;
  assign out_key         = okey_r;
  assign out_priority    = oprio_r;
  assign out_status      = st_r;
  assign out_entry_count = cnt32[CNT_OW-1:0];
endmodule
`default_nettype wire

// ===== sv/indexed_min_heap_queue.sv =====
// Top level of the indexed min-heap priority queue.
// Depends on imhq_pkg, imhq_ctrl, imhq_dp (and imhq_ram through it).
//
// Usage:
//   Command channel: drive in_cmd, in_item_key, in_item_priority with start
//   high; the transaction is taken at a rising edge where start is high and
//   busy is low. Commands: insert, extract minimum, change priority.
//   Result channel: out_valid is high for exactly one cycle per command,
//   carrying out_key, out_priority, out_status and out_entry_count. The
//   receiver cannot stall; the result must be captured in that cycle.
// Timing:
//   Each sift level is a registered RAM read followed by a compare and
//   swap. A command passes through latch and dispatch (plus a take step
//   for extract and change), walks the sift levels and ends with a write-back
//   of the moving entry, unless an extract empties the heap. Error answers
//   (full, empty, absent, duplicate) finish at dispatch. The next command may
//   be taken in the cycle its predecessor's result is shown.
// Reset:
//   rst_n low clears the entry count and all key-present flags; heap and
//   slot-map RAMs need no clearing since only valid entries are ever used.
`default_nettype none
module indexed_min_heap_queue import imhq_pkg::*; #(
  parameter int CAPACITY      = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [KEY_W-1:0]  in_item_key,
  input  wire logic [INP_W-1:0]  in_item_priority,
  output logic                   out_valid,
  output logic [KEY_W-1:0]       out_key,
  output logic [INP_W-1:0]       out_priority,
  output logic [2:0]             out_status,
  output logic [CNT_OW-1:0]      out_entry_count
);
  ctl_t   ctl;
  flags_t flags;

  // sequencer: decode and sift stepping
  imhq_ctrl u_ctrl (
    .clk, .rst_n, .start, .flags, .busy, .ctl
  );

  // storage, comparators and result registers
  imhq_dp #(.CAPACITY(CAPACITY), .PRIORITY_BITS(PRIORITY_BITS)) u_dp (
    .clk, .rst_n, .in_cmd, .in_item_key, .in_item_priority, .ctl, .flags,
    .out_valid, .out_key, .out_priority, .out_status, .out_entry_count
  );
endmodule
`default_nettype wire
